@@ sv/bhpq_pkg.sv @@
// Shared types and codes for the binary heap priority queue.
// No dependencies; compile first.
package bhpq_pkg;

  localparam int OUT_DATA_W = 72;

  // Operation carried in the input tuser
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status carried in the output tuser
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped_value;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [31:0] top_value;
  } result_t;

endpackage

@@ sv/bhpq_cmp.sv @@
// Shared priority compare unit for the heap queue.
// Depends on nothing; used by bhpq_ctrl for every sift step.
module bhpq_cmp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  largest_first,
  input  logic [VALUE_BITS-1:0] parent_val,
  input  logic [VALUE_BITS-1:0] child_val,
  output logic                  misordered
);

  logic [VALUE_BITS-1:0] lhs;
  logic [VALUE_BITS-1:0] rhs;

  // One magnitude comparator: swap operands for smallest-first order
  always_comb begin
    if (largest_first) begin
      lhs = parent_val;
      rhs = child_val;
    end else begin
      lhs = child_val;
      rhs = parent_val;
    end
    misordered = lhs < rhs;
  end

endmodule

@@ sv/bhpq_ctrl.sv @@
// Heap sequencer: holds the heap memory and the entry count, and walks
// sift-up and sift-down one level at a time through bhpq_cmp. Uses bhpq_pkg.
module bhpq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    largest_first,
  input  logic                    in_valid,
  input  logic [1:0]              in_kind,
  input  logic [VALUE_BITS-1:0]   in_value,
  output logic                    in_ready,
  output bhpq_pkg::result_t       res,
  output logic                    res_valid,
  input  logic                    res_ready
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_POP0 = 12'b000000000010,
    S_POPL = 12'b000000000100,
    S_DN   = 12'b000000001000,
    S_DNL  = 12'b000000010000,
    S_DNR  = 12'b000000100000,
    S_DNS  = 12'b000001000000,
    S_UP   = 12'b000010000000,
    S_UPC  = 12'b000100000000,
    S_FIN  = 12'b001000000000,
    S_TOP  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         best_r, best_nxt;
  logic [VALUE_BITS-1:0] cur_r, cur_nxt;
  logic [VALUE_BITS-1:0] bv_r, bv_nxt;
  logic [VALUE_BITS-1:0] popped_r, popped_nxt;
  logic [1:0]            status_r, status_nxt;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic [IW-1:0]         l_idx;
  logic [IW-1:0]         r_idx;
  logic [IW-1:0]         count_ext;
  logic [AW-1:0]         parent_idx;
  logic [VALUE_BITS-1:0] cmp_parent;
  logic [VALUE_BITS-1:0] cmp_child;
  logic                  cmp_mis;
  logic [63:0]           popped_w;
  logic [63:0]           top_w;

  assign l_idx      = {1'b0, pos_r, 1'b1};
  assign r_idx      = l_idx + IW'(1);
  assign count_ext  = IW'(count_r);
  assign parent_idx = (pos_r - AW'(1)) >> 1;

  always_comb begin
    unique case (state_r)
      S_UPC: begin
        cmp_parent = rd_data_r;
        cmp_child  = cur_r;
      end
      S_DNR: begin
        cmp_parent = bv_r;
        cmp_child  = rd_data_r;
      end
      default: begin
        cmp_parent = cur_r;
        cmp_child  = rd_data_r;
      end
    endcase
  end

  bhpq_cmp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_cmp (
    .largest_first (largest_first),
    .parent_val    (cmp_parent),
    .child_val     (cmp_child),
    .misordered    (cmp_mis)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    best_nxt   = best_r;
    cur_nxt    = cur_r;
    bv_nxt     = bv_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = cur_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          popped_nxt = '0;
          status_nxt = ST_OK;
          state_nxt  = S_TOP;
          unique case (in_kind)
            KIND_PUSH: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                cur_nxt   = in_value;
                pos_nxt   = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP;
              end
            end
            KIND_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                count_nxt = count_r - CW'(1);
                state_nxt = S_POP0;
              end
            end
            KIND_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      S_POP0: begin
        popped_nxt = rd_data_r;
        if (count_r == '0) begin
          state_nxt = S_TOP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = count_r[AW-1:0];
          state_nxt = S_POPL;
        end
      end
      S_POPL: begin
        cur_nxt   = rd_data_r;
        pos_nxt   = '0;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (l_idx >= count_ext) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = l_idx[AW-1:0];
          state_nxt = S_DNL;
        end
      end
      S_DNL: begin
        if (cmp_mis) begin
          best_nxt = l_idx[AW-1:0];
          bv_nxt   = rd_data_r;
        end else begin
          best_nxt = pos_r;
          bv_nxt   = cur_r;
        end
        if (r_idx < count_ext) begin
          rd_en     = 1'b1;
          rd_addr   = r_idx[AW-1:0];
          state_nxt = S_DNR;
        end else begin
          state_nxt = S_DNS;
        end
      end
      S_DNR: begin
        if (cmp_mis) begin
          best_nxt = r_idx[AW-1:0];
          bv_nxt   = rd_data_r;
        end
        state_nxt = S_DNS;
      end
      S_DNS: begin
        if (best_r == pos_r) begin
          state_nxt = S_FIN;
        end else begin
          // move the better child up into the hole
          wr_en     = 1'b1;
          wr_data   = bv_r;
          pos_nxt   = best_r;
          state_nxt = S_DN;
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = parent_idx;
          state_nxt = S_UPC;
        end
      end
      S_UPC: begin
        if (cmp_mis) begin
          // drop the parent into the hole and climb
          wr_en     = 1'b1;
          wr_data   = rd_data_r;
          pos_nxt   = parent_idx;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        wr_en     = 1'b1;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        rd_en     = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    best_r   <= best_nxt;
    cur_r    <= cur_nxt;
    bv_r     <= bv_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign popped_w = 64'(popped_r);
  assign top_w    = 64'(rd_data_r);

  always_comb begin
    res.status       = status_r;
    res.popped_value = popped_w[31:0];
    res.entry_count  = 5'(count_r);
    res.is_empty     = (count_r == '0);
    res.top_value    = (count_r == '0) ? 32'd0 : top_w[31:0];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == KIND_PUSH && count_r != CW'(DEPTH))
    |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted push did not add an entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == KIND_POP && count_r != '0)
    |=> count_r == $past(count_r) - CW'(1))
    else $error("accepted pop did not remove an entry");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed before hand-off");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready || res_valid) |-> !wr_en)
    else $error("heap written outside a sift");
`endif

endmodule

@@ sv/binary_heap_priority_queue_core.sv @@
// Binary heap priority queue, up to DEPTH entries of VALUE_BITS each, ordered
// smallest-first or largest-first by cfg. The length of an input transaction
// is set by the sift walk of one sequencer over a single-port heap memory. A
// push climbs toward the root one level at a time, and a pop moves the last
// entry down one level at a time; a pop that empties the queue, a clear, a
// rejected operation and an unused kind do no sift walk. A sift walks at most
// log2(DEPTH) levels. A finished result waits in the output register, and the
// next transaction is taken meanwhile.
// Depends on bhpq_pkg, bhpq_ctrl and bhpq_cmp.
module binary_heap_priority_queue_core #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,   // largest_first
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,      // [31:0] entry_value
  input  logic [1:0]                      in_tuser,      // [1:0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] popped_value, [36:32] entry_count, [37] is_empty,
  // [69:38] top_value, [71:70] zero
  output logic [bhpq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser      // [1:0] status
);
  import bhpq_pkg::*;

  logic                  largest_first_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [1:0]            out_tuser_r;
  result_t               res;
  logic                  res_valid;
  logic                  res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      largest_first_r <= 1'b0;
    end else if (cfg_wr_en) begin
      largest_first_r <= cfg_wr_data;
    end
  end

  bhpq_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .largest_first (largest_first_r),
    .in_valid      (in_tvalid),
    .in_kind       (in_tuser),
    .in_value      (VALUE_BITS'(in_tdata)),
    .in_ready      (in_tready),
    .res           (res),
    .res_valid     (res_valid),
    .res_ready     (res_ready)
  );

  // Output register: load whenever the slot is empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= {2'b00, res.top_value, res.is_empty, res.entry_count,
                      res.popped_value};
      out_tuser_r <= res.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
